// File: hdl/pps_pkg.sv
// shared types, constants and the arctangent table for the pure pursuit steering core
`default_nettype none
package pps_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int ITERS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(ITERS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(13);
	localparam logic [CNT_W-1:0] K_MAX     = CNT_W'(31);

	localparam int OFS_W = 33;
	localparam int CRD_W = 56;
	localparam int ANG_W = 34;
	localparam int PRD_W = 50;

	localparam logic [15:0] STEER_ONE = 16'd16384;
	localparam logic        REG_MAX_STEER = 1'b0;
	localparam logic        REG_DRIVE_EN  = 1'b1;
	localparam logic        OP_UPDATE  = 1'b0;
	localparam logic        OP_REQUEST = 1'b1;

	typedef enum logic [3:0] {
		DP_HOLD,
		DP_CAPTURE,
		DP_NORM,
		DP_ZERO,
		DP_VLOAD,
		DP_VEC,
		DP_ALPHA,
		DP_ROT,
		DP_MUL,
		DP_SHIFT,
		DP_DIVLD,
		DP_DIV,
		DP_LATCH
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [CNT_W-1:0]  iter;
	} dp_cmd_t;

	typedef struct packed {
		logic zero_case;
		logic norm_done;
	} dp_stat_t;

	function automatic logic [31:0] atan_lut(input logic [CNT_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000002;
			5'd29: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/pps_if.sv
// request and result channel interfaces of the pure pursuit steering core
`default_nettype none
interface pps_item_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] vehicle_x;
	logic signed [31:0] vehicle_y;
	logic signed [15:0] heading;
	logic [15:0]        axle_spacing;
	modport source (output valid, opcode, target_x, target_y, vehicle_x, vehicle_y,
		heading, axle_spacing, input ready);
	modport sink (input valid, opcode, target_x, target_y, vehicle_x, vehicle_y,
		heading, axle_spacing, output ready);
endinterface

interface pps_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] steer;
	modport source (output valid, steer, input ready);
	modport sink (input valid, steer, output ready);
endinterface
`default_nettype wire

// File: hdl/pps_datapath.sv
// datapath: offset normalisation, shared cordic unit, multiplier and steer divider
`default_nettype none
module pps_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pps_pkg::dp_cmd_t    cmd,
	output pps_pkg::dp_stat_t        stat,
	input  wire logic signed [31:0]  target_x,
	input  wire logic signed [31:0]  target_y,
	input  wire logic signed [31:0]  vehicle_x,
	input  wire logic signed [31:0]  vehicle_y,
	input  wire logic signed [15:0]  heading,
	input  wire logic [15:0]         axle_spacing,
	input  wire logic [14:0]         max_steer,
	output logic [15:0]              held_steer
);

	logic signed [pps_pkg::OFS_W-1:0] dx_q, dy_q, dx_in, dy_in;
	logic [pps_pkg::OFS_W-1:0]        adx, ady, mx_in, mx_q;
	logic [pps_pkg::CNT_W-1:0]        k_q;
	logic [15:0]                      wb_q, hd_q;
	logic signed [pps_pkg::CRD_W-1:0] x_q, y_q, mag_q, xs, ys, x_nx, y_nx;
	logic signed [pps_pkg::CRD_W-1:0] src_x, src_y, num_ext, num_sh;
	logic signed [pps_pkg::ANG_W-1:0] z_q, z_nx, at_ext;
	logic signed [pps_pkg::PRD_W-1:0] prod_q, prod;
	logic [31:0]                      at, a0, a1;
	logic                             dir;
	logic [33:0]                      rem_q, rem_in;
	logic [29:0]                      dv_q;
	logic [13:0]                      quo_q;
	logic                             clamp_q, neg_q, ge;
	logic [32:0]                      abs_delta;
	logic [15:0]                      mag16;

	always_comb begin
		dx_in = {target_x[31], target_x} - {vehicle_x[31], vehicle_x};
		dy_in = {target_y[31], target_y} - {vehicle_y[31], vehicle_y};
		adx = dx_in[pps_pkg::OFS_W-1] ? -dx_in : dx_in;
		ady = dy_in[pps_pkg::OFS_W-1] ? -dy_in : dy_in;
		mx_in = (adx > ady) ? adx : ady;

		stat.norm_done = (mx_q[32:31] != 2'b00) || (k_q == pps_pkg::K_MAX);
		stat.zero_case = ((dx_q == '0) && (dy_q == '0)) || (wb_q == '0) || (max_steer == '0);

		xs = x_q >>> cmd.iter;
		ys = y_q >>> cmd.iter;
		at = pps_pkg::atan_lut(cmd.iter);
		at_ext = {2'b00, at};
		dir = (cmd.op == pps_pkg::DP_VEC) ? y_q[pps_pkg::CRD_W-1] : !z_q[pps_pkg::ANG_W-1];
		x_nx = dir ? x_q - ys : x_q + ys;
		y_nx = dir ? y_q + xs : y_q - xs;
		z_nx = dir ? z_q - at_ext : z_q + at_ext;

		a0 = z_q[31:0] - {hd_q, 16'h0000};
		a1 = (a0 >= 32'h4000_0000 && a0 < 32'hC000_0000) ? 32'h8000_0000 - a0 : a0;

		prod = $signed({1'b0, wb_q}) * $signed(y_q[32:0]);
		num_ext = {{(pps_pkg::CRD_W-pps_pkg::PRD_W-1){prod_q[pps_pkg::PRD_W-1]}}, prod_q, 1'b0};
		num_sh = (k_q == pps_pkg::K_MAX) ? (num_ext <<< 1) : (num_ext >>> (5'd30 - k_q));

		if (cmd.op == pps_pkg::DP_VLOAD) begin
			src_x = {{(pps_pkg::CRD_W-pps_pkg::OFS_W){dx_q[pps_pkg::OFS_W-1]}}, dx_q};
			src_y = {{(pps_pkg::CRD_W-pps_pkg::OFS_W){dy_q[pps_pkg::OFS_W-1]}}, dy_q};
		end else begin
			src_x = mag_q;
			src_y = num_sh;
		end

		abs_delta = z_q[31] ? -{1'b1, z_q[31:0]} : {1'b0, z_q[31:0]};
		rem_in = {1'b0, abs_delta} + {18'd0, max_steer, 1'b0};
		ge = rem_q >= {4'd0, dv_q};
		mag16 = clamp_q ? pps_pkg::STEER_ONE : {2'b00, quo_q};
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			pps_pkg::DP_CAPTURE: begin
				dx_q <= dx_in;
				dy_q <= dy_in;
				mx_q <= mx_in;
				k_q  <= '0;
				wb_q <= axle_spacing;
				hd_q <= heading;
			end
			pps_pkg::DP_NORM: begin
				dx_q <= dx_q <<< 1;
				dy_q <= dy_q <<< 1;
				mx_q <= mx_q << 1;
				k_q  <= k_q + 5'd1;
			end
			pps_pkg::DP_VLOAD, pps_pkg::DP_SHIFT: begin
				x_q <= src_x[pps_pkg::CRD_W-1] ? -src_x : src_x;
				y_q <= src_x[pps_pkg::CRD_W-1] ? -src_y : src_y;
				z_q <= src_x[pps_pkg::CRD_W-1] ? 34'sh0_8000_0000 : '0;
			end
			pps_pkg::DP_VEC, pps_pkg::DP_ROT: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
			end
			pps_pkg::DP_ALPHA: begin
				mag_q <= x_q;
				x_q   <= 56'sd1 <<< 30;
				y_q   <= '0;
				z_q   <= {{2{a1[31]}}, a1};
			end
			pps_pkg::DP_MUL: prod_q <= prod;
			pps_pkg::DP_DIVLD: begin
				rem_q   <= rem_in;
				clamp_q <= rem_in >= {3'd0, max_steer, 16'h0000};
				dv_q    <= {max_steer, 15'd0};
				neg_q   <= z_q[31];
				quo_q   <= '0;
			end
			pps_pkg::DP_DIV: begin
				if (ge) begin
					rem_q <= rem_q - {4'd0, dv_q};
				end
				quo_q <= {quo_q[12:0], ge};
				dv_q  <= dv_q >> 1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_steer <= '0;
		end else if (cmd.op == pps_pkg::DP_ZERO) begin
			held_steer <= '0;
		end else if (cmd.op == pps_pkg::DP_LATCH) begin
			held_steer <= neg_q ? -mag16 : mag16;
		end
	end

endmodule
`default_nettype wire

// File: hdl/pps_ctrl.sv
// controller state machine sequencing one steer update through the datapath
`default_nettype none
module pps_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire pps_pkg::dp_stat_t stat,
	output pps_pkg::dp_cmd_t       cmd,
	output logic                   idle,
	output logic                   steer_valid
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_NORM  = 11'b000_0000_0010,
		S_VEC1  = 11'b000_0000_0100,
		S_ALPHA = 11'b000_0000_1000,
		S_ROT   = 11'b000_0001_0000,
		S_MUL   = 11'b000_0010_0000,
		S_SHIFT = 11'b000_0100_0000,
		S_VEC2  = 11'b000_1000_0000,
		S_DIVLD = 11'b001_0000_0000,
		S_DIV   = 11'b010_0000_0000,
		S_LATCH = 11'b100_0000_0000
	} state_t;

	state_t                     state_q, state_d;
	logic [pps_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	logic                       steer_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd.op   = pps_pkg::DP_HOLD;
		cmd.iter = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = pps_pkg::DP_CAPTURE;
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				if (stat.zero_case) begin
					cmd.op  = pps_pkg::DP_ZERO;
					state_d = S_IDLE;
				end else if (stat.norm_done) begin
					cmd.op  = pps_pkg::DP_VLOAD;
					cnt_d   = '0;
					state_d = S_VEC1;
				end else begin
					cmd.op = pps_pkg::DP_NORM;
				end
			end
			S_VEC1, S_ROT, S_VEC2: begin
				cmd.op = (state_q == S_ROT) ? pps_pkg::DP_ROT : pps_pkg::DP_VEC;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == pps_pkg::ITER_LAST) begin
					cnt_d = '0;
					unique case (state_q)
						S_VEC1:  state_d = S_ALPHA;
						S_ROT:   state_d = S_MUL;
						default: state_d = S_DIVLD;
					endcase
				end
			end
			S_ALPHA: begin
				cmd.op  = pps_pkg::DP_ALPHA;
				state_d = S_ROT;
			end
			S_MUL: begin
				cmd.op  = pps_pkg::DP_MUL;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.op  = pps_pkg::DP_SHIFT;
				state_d = S_VEC2;
			end
			S_DIVLD: begin
				cmd.op  = pps_pkg::DP_DIVLD;
				cnt_d   = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = pps_pkg::DP_DIV;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == pps_pkg::DIV_LAST) begin
					cnt_d   = '0;
					state_d = S_LATCH;
				end
			end
			S_LATCH: begin
				cmd.op  = pps_pkg::DP_LATCH;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			steer_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.op == pps_pkg::DP_ZERO || cmd.op == pps_pkg::DP_LATCH) begin
				steer_valid_q <= 1'b1;
			end
		end
	end

	assign idle        = (state_q == S_IDLE);
	assign steer_valid = steer_valid_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE) else $error("update started while busy");
	a_start_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> state_q == S_NORM) else $error("start not taken");
	a_latch_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LATCH |=> steer_valid_q && state_q == S_IDLE) else $error("latch lost");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VEC1 || state_q == S_ROT || state_q == S_VEC2) |-> cnt_q <= pps_pkg::ITER_LAST)
		else $error("iteration count overrun");

endmodule
`default_nettype wire

// File: hdl/pure_pursuit_steering_core.sv
// top level of the pure pursuit steering core: channels, register port and result stage
// an update holds the core through capture, up to 31 normalising shifts, three
// cordic passes of 16 iterations on the shared unit, multiply, shift and a 14-step divider
// a zero offset, zero wheelbase or zero max steer latches a zero steer
// with drive on and a steer latched, a request gets the held steer via the result register
// one update is in flight at a time; new requests wait until it has latched its steer
// asynchronous active-low reset clears the registers to their defaults and the held steer
`default_nettype none
module pure_pursuit_steering_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pps_item_if.sink         item,
	pps_result_if.source     result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [14:0]       max_steer_q;
	logic              drive_en_q;
	logic              out_valid_q;
	logic [15:0]       out_steer_q;
	logic              idle, steer_valid, item_fire, start;
	logic [15:0]       held_steer;
	pps_pkg::dp_cmd_t  cmd;
	pps_pkg::dp_stat_t stat;

	assign pready     = 1'b1;
	assign prdata     = (paddr[2] == pps_pkg::REG_DRIVE_EN) ? {31'd0, drive_en_q}
		: {17'd0, max_steer_q};
	assign item.ready = idle && (!out_valid_q || result.ready);
	assign item_fire  = item.valid && item.ready;
	assign start      = item_fire && (item.opcode == pps_pkg::OP_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steer_q <= 15'd10430;
			drive_en_q  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == pps_pkg::REG_MAX_STEER) begin
				max_steer_q <= pwdata[14:0];
			end else begin
				drive_en_q <= pwdata[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_fire && item.opcode == pps_pkg::OP_REQUEST && drive_en_q
				&& steer_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			out_steer_q <= held_steer;
		end
	end

	assign result.valid = out_valid_q;
	assign result.steer = out_steer_q;

	pps_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.stat        (stat),
		.cmd         (cmd),
		.idle        (idle),
		.steer_valid (steer_valid)
	);

	pps_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.target_x     (item.target_x),
		.target_y     (item.target_y),
		.vehicle_x    (item.vehicle_x),
		.vehicle_y    (item.vehicle_y),
		.heading      (item.heading),
		.axle_spacing (item.axle_spacing),
		.max_steer    (max_steer_q),
		.held_steer   (held_steer)
	);

endmodule
`default_nettype wire
